>>> sv/fenwick_order_statistic_list_top_defines.svh
// Assertion macros shared by the checker file of the order-statistic list.
`ifndef FENWICK_ORDER_STATISTIC_LIST_TOP_DEFINES_SVH
`define FENWICK_ORDER_STATISTIC_LIST_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FOSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fosl assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FOSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fosl assertion failed");

`endif

>>> sv/fosl_pkg.sv
// ----------------------------------------------------------------------------
// Order-statistic list package
// Transaction types, status codes and sequencer states.
// ----------------------------------------------------------------------------
package fosl_pkg;

   localparam int VALUE_W  = 32;
   localparam int RANK_W   = 11;
   localparam int STATUS_W = 2;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic               op;
      logic [VALUE_W-1:0] value;
      logic [RANK_W-1:0]  rank;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  taken_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_FIND_END,
      ST_UPD_RD,
      ST_UPD_WR
   } state_type;

endpackage

>>> sv/fenwick_order_statistic_list_top.sv
// ----------------------------------------------------------------------------
// Order-statistic list top level
// Ordered list of words kept with a binary indexed tree of live counts.
// ----------------------------------------------------------------------------
//
//   channel   ports                       handshake
//   request   start, busy, req_data       taken when start and not busy
//   response  rsp_strobe, rsp_data        one cycle, cannot be held off
//
// After reset the count memory is cleared, one entry a cycle, with busy high.
// An append updates L nodes. A take walks T = floor(log2(CAPACITY)) + 1 search
// levels, each a read state and, for a probe in range, a compare state, and if
// the rank is found updates L <= T nodes, each a read and a write state. A full
// append or a rank of zero answers in the next cycle. One transaction is in
// work at a time, and the result strobe cannot stall.
module fenwick_order_statistic_list_top #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fosl_pkg::req_type req_data,
   output logic              rsp_strobe,
   output fosl_pkg::rsp_type rsp_data
);
   import fosl_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int SW    = $clog2(CAPACITY + 1);
   localparam int CW    = SW;
   localparam int CMPW  = (CW > RANK_W) ? CW : RANK_W;
   localparam int TOP_LOG = SW - 1;
   localparam logic [SW-1:0]  TOP_POWER = SW'(1) << TOP_LOG;
   localparam logic [SW:0]    CAP_WIDE  = (SW + 1)'(CAPACITY);
   localparam logic [SW-1:0]  CAP_SLOT  = SW'(CAPACITY);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(CAPACITY - 1);

   // Memories.
   logic [CW-1:0]      cnt_mem [CAPACITY];
   logic [VALUE_W-1:0] val_mem [CAPACITY];

   logic               cnt_we;
   logic [AW-1:0]      cnt_waddr;
   logic [CW-1:0]      cnt_wdata;
   logic [AW-1:0]      cnt_raddr;
   logic [CW-1:0]      cnt_rd_ff;
   logic               val_we;
   logic [VALUE_W-1:0] val_rd_ff;

   // Sequencer registers.
   state_type      state_ff, state_in;
   logic [SW-1:0]  next_slot_ff, next_slot_in;
   logic [RANK_W-1:0] k_ff, k_in;
   logic [SW-1:0]  pos_ff, pos_in;
   logic [SW-1:0]  mask_ff, mask_in;
   logic [SW-1:0]  idx_ff, idx_in;
   logic           up_ff, up_in;
   logic [AW-1:0]  val_addr_ff, val_addr_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic [SW:0]    probe;
   logic [SW-1:0]  low_bit;
   logic [SW:0]    idx_next;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[next_slot_ff[AW-1:0]] <= req_data.value;
      end
      val_rd_ff <= val_mem[val_addr_ff];
   end

   assign probe    = {1'b0, pos_ff} + {1'b0, mask_ff};
   assign low_bit  = idx_ff & (~idx_ff + SW'(1));
   assign idx_next = {1'b0, idx_ff} + {1'b0, low_bit};

   always_comb begin
      state_in     = state_ff;
      next_slot_in = next_slot_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      mask_in      = mask_ff;
      idx_in       = idx_ff;
      up_in        = up_ff;
      val_addr_in  = val_addr_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = clr_ff;
      cnt_wdata    = '0;
      cnt_raddr    = AW'(idx_ff - SW'(1));
      val_we       = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            cnt_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.op == OP_APPEND) begin
                  if (next_slot_ff >= CAP_SLOT) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{status: STATUS_FULL, taken_value: '0};
                  end else begin
                     val_we       = 1'b1;
                     next_slot_in = next_slot_ff + SW'(1);
                     idx_in       = next_slot_ff + SW'(1);
                     up_in        = 1'b1;
                     state_in     = ST_UPD_RD;
                  end
               end else if (req_data.rank == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{status: STATUS_NONE, taken_value: '0};
               end else begin
                  k_in     = req_data.rank;
                  pos_in   = '0;
                  mask_in  = TOP_POWER;
                  state_in = ST_FIND_RD;
               end
            end
         end
         ST_FIND_RD: begin
            cnt_raddr = AW'(probe - (SW + 1)'(1));
            if (probe <= CAP_WIDE) begin
               state_in = ST_FIND_CMP;
            end else begin
               // Probe lies past the last node: skip this level.
               mask_in = mask_ff >> 1;
               if (mask_ff == SW'(1)) begin
                  state_in = ST_FIND_END;
               end
            end
         end
         ST_FIND_CMP: begin
            if (CMPW'(cnt_rd_ff) < CMPW'(k_ff)) begin
               pos_in = probe[SW-1:0];
               k_in   = k_ff - RANK_W'(cnt_rd_ff);
            end
            mask_in = mask_ff >> 1;
            if (mask_ff == SW'(1)) begin
               state_in = ST_FIND_END;
            end else begin
               state_in = ST_FIND_RD;
            end
         end
         ST_FIND_END: begin
            // A walk that ran off the end means the rank exceeds the live count.
            if (pos_ff == CAP_SLOT) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STATUS_NONE, taken_value: '0};
               state_in     = ST_IDLE;
            end else begin
               val_addr_in = pos_ff[AW-1:0];
               idx_in      = pos_ff + SW'(1);
               up_in       = 1'b0;
               state_in    = ST_UPD_RD;
            end
         end
         ST_UPD_RD: begin
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = AW'(idx_ff - SW'(1));
            cnt_wdata = up_ff ? (cnt_rd_ff + CW'(1)) : (cnt_rd_ff - CW'(1));
            if (idx_next > CAP_WIDE) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: STATUS_OK,
                                taken_value: (up_ff ? '0 : val_rd_ff)};
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_next[SW-1:0];
               state_in = ST_UPD_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_slot_ff <= next_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      mask_ff     <= mask_in;
      idx_ff      <= idx_in;
      up_ff       <= up_in;
      val_addr_ff <= val_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> sv/fosl_checker.sv
// ----------------------------------------------------------------------------
// Order-statistic list port checker
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`include "fenwick_order_statistic_list_top_defines.svh"

module fosl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input fosl_pkg::req_type req_data,
   input logic              rsp_strobe,
   input fosl_pkg::rsp_type rsp_data
);
   import fosl_pkg::*;

   // An accepted transaction either answers at once or keeps the block busy.
   `FOSL_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)

   // No result appears without a transaction in work or just accepted.
   `FOSL_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !busy && !start, !rsp_strobe)

   // Only a successful take carries a value.
   `FOSL_ASSERT_NOW(a_zero_on_fail, clock, reset,
                    rsp_strobe && (rsp_data.status != STATUS_OK), rsp_data.taken_value == '0)

   // Status codes stay within the defined set.
   `FOSL_ASSERT_NOW(a_status_code, clock, reset, rsp_strobe,
                    (rsp_data.status == STATUS_OK) || (rsp_data.status == STATUS_NONE) ||
                    (rsp_data.status == STATUS_FULL))

endmodule

bind fenwick_order_statistic_list_top fosl_checker u_fosl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

>>> tb/tb_fenwick_order_statistic_list_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Order-statistic list testbench
// Sends append and take transactions to the list and compares every result
// with a behavioral model of the count tree kept inside the bench.
// ----------------------------------------------------------------------------
module tb_fenwick_order_statistic_list_top;
   import fosl_pkg::*;

   localparam int CAPACITY    = 1024;
   localparam int TOP_POWER   = (2 ** $clog2(CAPACITY + 1)) / 2;
   localparam int MAX_RANK    = 1024;
   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_ITEMS = 250;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_LIMIT = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Bench copy of the list state.
   logic [RANK_W-1:0]  live_tree [1:CAPACITY];
   logic [VALUE_W-1:0] word_at [1:CAPACITY];
   int unsigned        slots_used = 0;
   int unsigned        live_total = 0;

   rsp_type     expected_rsp [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          sender_idles = 1'b1;

   fenwick_order_statistic_list_top #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      for (int i = 1; i <= CAPACITY; i++) begin
         live_tree[i] = '0;
         word_at[i]   = '0;
      end
   end

   function automatic void adjust_counts(int slot, bit grow);
      for (int i = slot; i <= CAPACITY; i += i & (-i)) begin
         if (grow) begin
            live_tree[i] = live_tree[i] + 1'b1;
         end else begin
            live_tree[i] = live_tree[i] - 1'b1;
         end
      end
   endfunction

   // Applies one transaction to the bench list and returns the result it causes.
   function automatic rsp_type apply_to_list(req_type item);
      rsp_type     outcome;
      int unsigned pos;
      int unsigned probe;
      int unsigned remaining;
      int unsigned slot;
      outcome.status      = STATUS_OK;
      outcome.taken_value = '0;
      if (item.op == OP_APPEND) begin
         if (slots_used >= CAPACITY) begin
            outcome.status = STATUS_FULL;
         end else begin
            slots_used++;
            live_total++;
            word_at[slots_used] = item.value;
            adjust_counts(slots_used, 1'b1);
         end
      end else begin
         slot = CAPACITY + 1;
         if (item.rank != 0) begin
            pos       = 0;
            remaining = item.rank;
            for (int unsigned mask = TOP_POWER; mask != 0; mask >>= 1) begin
               probe = pos + mask;
               if (probe <= CAPACITY && live_tree[probe] < remaining) begin
                  remaining -= live_tree[probe];
                  pos = probe;
               end
            end
            slot = pos + 1;
         end
         if (slot > CAPACITY) begin
            outcome.status = STATUS_NONE;
         end else begin
            outcome.taken_value = word_at[slot];
            word_at[slot] = '0;
            live_total--;
            adjust_counts(slot, 1'b0);
         end
      end
      return outcome;
   endfunction

   function automatic req_type append_of(logic [VALUE_W-1:0] word);
      req_type item;
      item.op    = OP_APPEND;
      item.value = word;
      item.rank  = RANK_W'($urandom_range(0, MAX_RANK));
      return item;
   endfunction

   function automatic req_type take_of(int unsigned wanted_rank);
      req_type item;
      item.op    = OP_TAKE;
      item.value = $urandom;
      item.rank  = RANK_W'(wanted_rank);
      return item;
   endfunction

   // Mostly ranks that hit a live element, some zero or past the end.
   function automatic int unsigned pick_rank();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70 && live_total > 0) begin
         return $urandom_range(1, live_total);
      end else if (roll < 80) begin
         return 0;
      end else if (roll < 90 && live_total < MAX_RANK) begin
         return $urandom_range(live_total + 1, MAX_RANK);
      end
      return $urandom_range(0, MAX_RANK);
   endfunction

   task automatic flag_error(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t ns: %s", $realtime, msg);
      end
   endtask

   // Sends one transaction; start stays high afterward so that a following
   // transaction can go out back to back.
   task automatic send_request(req_type item);
      if (sender_idles && $urandom_range(99) < 18) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      expected_rsp.push_back(apply_to_list(item));
   endtask

   task automatic test_empty_list();
      send_request(take_of(1));
      send_request(take_of(0));
      send_request(take_of(MAX_RANK));
   endtask

   task automatic test_append_and_take();
      send_request(append_of(32'h0000_0000));
      send_request(append_of(32'hFFFF_FFFF));
      send_request(append_of(32'hAAAA_AAAA));
      send_request(append_of(32'h5555_5555));
      send_request(append_of(32'h1234_5678));
      send_request(take_of(0));
      send_request(take_of(live_total + 1));
      send_request(take_of(MAX_RANK));
      send_request(take_of(live_total));
      send_request(take_of(2));
      // Removed slots leave equal prefix counts; the lowest live slot must win.
      send_request(take_of(1));
      send_request(take_of(1));
      send_request(take_of(2));
      send_request(take_of(1));
      send_request(take_of(1));
   endtask

   task automatic test_random_mix();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_idles = (n >= QUIET_ITEMS);
         if ($urandom_range(99) < 55) begin
            send_request(append_of($urandom));
         end else begin
            send_request(take_of(pick_rank()));
         end
      end
      sender_idles = 1'b1;
   endtask

   task automatic test_fill_to_full();
      while (slots_used < CAPACITY) begin
         if ($urandom_range(99) < 90) begin
            send_request(append_of($urandom));
         end else begin
            send_request(take_of(pick_rank()));
         end
      end
      send_request(append_of($urandom));
      send_request(append_of(32'hFFFF_FFFF));
      send_request(take_of(live_total));
      send_request(take_of(1));
      send_request(take_of(MAX_RANK));
      for (int n = 0; n < 20; n++) begin
         send_request(take_of(pick_rank()));
      end
      send_request(append_of($urandom));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            flag_error($sformatf("result with nothing outstanding: status %0d value %h",
                                 rsp_data.status, rsp_data.taken_value));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               flag_error($sformatf("status mismatch: expected %0d, got %0d",
                                    want.status, rsp_data.status));
            end
            if (rsp_data.taken_value !== want.taken_value) begin
               flag_error($sformatf("taken_value mismatch: expected %h, got %h",
                                    want.taken_value, rsp_data.taken_value));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_append_and_take();
      test_random_mix();
      test_fill_to_full();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
